[hdl/uule_pkg.sv]
package uule_pkg;

  // Field widths fixed by the item format
  localparam int BYTE_W  = 8;
  localparam int LEN_W   = 6;
  localparam int CHAR_W  = 7;
  localparam int SUM_W   = 32;
  localparam int SLOTS   = 5;
  localparam int SLOT_W  = $clog2(SLOTS);

  // Default longest line in bytes
  localparam int MAX_LINE_BYTES_DEF = 45;

  // Character codes
  localparam logic [CHAR_W-1:0] CHAR_BASE = 7'h20;
  localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'h60;

  // Characters produced by one input item, ready for the emitter
  typedef struct packed {
    logic [SLOTS-1:0][CHAR_W-1:0] chars;
    logic [SLOT_W-1:0]            last_idx;
    logic                         eol;
    logic [SUM_W-1:0]             byte_sum;
  } bundle_t;

  // Emitter status seen by the top level
  typedef struct packed {
    logic              busy;
    logic [SLOT_W-1:0] idx;
    logic [SLOT_W-1:0] last_idx;
  } emit_stat_t;

  // Map a 6-bit value to its printable character; zero becomes a backquote
  function automatic logic [CHAR_W-1:0] six_to_char(input logic [5:0] v);
    logic [CHAR_W-1:0] c;
    if (v == 6'd0) begin
      c = CHAR_ZERO;
    end else begin
      c = CHAR_BASE + {1'b0, v};
    end
    return c;
  endfunction

endpackage

[hdl/uule_encode.sv]
module uule_encode import uule_pkg::*; #(
  parameter int MAX_LINE_BYTES = MAX_LINE_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BYTE_W-1:0] data_byte,
  input  logic              line_start,
  input  logic [LEN_W-1:0]  line_length,
  output logic              bnd_valid,
  input  logic              bnd_ready,
  output bundle_t           bnd
);

  // Line and group state
  logic [BYTE_W-1:0] held0, held1;
  logic [1:0]        group_fill;
  logic [LEN_W-1:0]  bytes_left;
  logic [SUM_W-1:0]  running_sum;

  logic [BYTE_W-1:0] held0_next, held1_next;
  logic [1:0]        group_fill_next;
  logic [LEN_W-1:0]  bytes_left_next;
  logic [SUM_W-1:0]  running_sum_next;

  logic              accept;
  logic [LEN_W-1:0]  len_sat, left_cur, left_dec;
  logic [1:0]        fill_cur;
  logic [BYTE_W-1:0] h0_cur, h1_cur, b0, b1, b2;
  logic              active, last, emit_group, has_out;
  logic [3*BYTE_W-1:0]              word;
  logic [3:0][CHAR_W-1:0]           grp;
  bundle_t           bnd_next;

  assign in_ready = !bnd_valid || bnd_ready;
  assign accept   = in_valid && in_ready;

  // Work out one item's characters and the following state
  always_comb begin
    len_sat  = (line_length > LEN_W'(MAX_LINE_BYTES)) ? LEN_W'(MAX_LINE_BYTES)
                                                      : line_length;
    left_cur = line_start ? len_sat : bytes_left;
    fill_cur = line_start ? 2'd0 : group_fill;
    h0_cur   = line_start ? '0 : held0;
    h1_cur   = line_start ? '0 : held1;
    active   = (left_cur != '0);
    left_dec = left_cur - LEN_W'(1);
    last     = (left_dec == '0);

    b0 = (fill_cur == 2'd0) ? data_byte : h0_cur;
    b1 = (fill_cur == 2'd1) ? data_byte : h1_cur;
    b2 = (fill_cur == 2'd2) ? data_byte : '0;
    emit_group = active && ((fill_cur == 2'd2) || last);

    word   = {b0, b1, b2};
    grp[0] = six_to_char(word[23:18]);
    grp[1] = six_to_char(word[17:12]);
    grp[2] = six_to_char(word[11:6]);
    grp[3] = six_to_char(word[5:0]);

    running_sum_next = running_sum + (active ? SUM_W'(data_byte) : '0);

    // Header character goes first when a line opens
    bnd_next.byte_sum = running_sum_next;
    bnd_next.eol      = line_start ? (!active || last) : last;
    if (line_start) begin
      bnd_next.chars[0] = CHAR_BASE + {1'b0, len_sat};
      bnd_next.chars[1] = grp[0];
      bnd_next.chars[2] = grp[1];
      bnd_next.chars[3] = grp[2];
      bnd_next.chars[4] = grp[3];
      bnd_next.last_idx = emit_group ? SLOT_W'(4) : SLOT_W'(0);
    end else begin
      bnd_next.chars[0] = grp[0];
      bnd_next.chars[1] = grp[1];
      bnd_next.chars[2] = grp[2];
      bnd_next.chars[3] = grp[3];
      bnd_next.chars[4] = grp[3];
      bnd_next.last_idx = SLOT_W'(3);
    end
    has_out = line_start || emit_group;

    // State update
    held0_next      = h0_cur;
    held1_next      = h1_cur;
    group_fill_next = fill_cur;
    bytes_left_next = left_cur;
    if (active) begin
      bytes_left_next = left_dec;
      if (emit_group) begin
        held0_next      = '0;
        held1_next      = '0;
        group_fill_next = 2'd0;
      end else begin
        if (fill_cur == 2'd0) begin
          held0_next = data_byte;
        end else begin
          held1_next = data_byte;
        end
        group_fill_next = fill_cur + 2'd1;
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      held0       <= '0;
      held1       <= '0;
      group_fill  <= '0;
      bytes_left  <= '0;
      running_sum <= '0;
    end else if (accept) begin
      held0       <= held0_next;
      held1       <= held1_next;
      group_fill  <= group_fill_next;
      bytes_left  <= bytes_left_next;
      running_sum <= running_sum_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      bnd_valid <= 1'b0;
    end else if (in_ready) begin
      bnd_valid <= accept && has_out;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && has_out) begin
      bnd <= bnd_next;
    end
  end

endmodule

[hdl/uule_emit.sv]
module uule_emit import uule_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              bnd_valid,
  output logic              bnd_ready,
  input  bundle_t           bnd,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CHAR_W-1:0] out_char,
  output logic              end_of_line,
  output logic [SUM_W-1:0]  byte_sum,
  output emit_stat_t        stat
);

  logic              busy;
  logic [SLOT_W-1:0] idx;
  bundle_t           cur;
  logic              at_last, done;

  assign at_last   = (idx == cur.last_idx);
  assign done      = busy && out_ready && at_last;
  assign bnd_ready = !busy || done;

  // Serialise the held characters one per cycle while out_ready is high
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (bnd_ready) begin
      busy <= bnd_valid;
      idx  <= '0;
    end else if (out_ready) begin
      idx <= idx + SLOT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (bnd_ready && bnd_valid) begin
      cur <= bnd;
    end
  end

  assign out_valid   = busy;
  assign out_char    = cur.chars[idx];
  assign end_of_line = at_last && cur.eol;
  assign byte_sum    = cur.byte_sum;

  assign stat.busy     = busy;
  assign stat.idx      = idx;
  assign stat.last_idx = cur.last_idx;

endmodule

[hdl/uu_line_encoder_top.sv]
// Line encoder for uuencoded text. Each input item carries one data byte; the
// item that opens a line also carries the line's byte count (capped at
// MAX_LINE_BYTES) and yields the length character. Every third byte of a line,
// or the line's last byte, yields four characters; a short final group is
// padded with zero bytes. Each output item carries one character, the running
// byte sum after the byte that produced it, and tlast on the last character of
// a line. With the emitter free, the first character of a byte passes the
// result register and the emitter's held item before it can leave, and the
// rest follow one per cycle while the receiver is ready. The output port moves
// one character per cycle when the receiver is ready, so a byte yields 0 to 5
// characters and the character emitter sets the rate of a steady stream.
// The input side keeps taking bytes while one item's characters are still
// being sent, until a finished item waits in the result register.
module uu_line_encoder_top import uule_pkg::*; #(
  parameter int MAX_LINE_BYTES = MAX_LINE_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // data_byte[7:0], line_length[13:8], zero[15:14]
  input  logic        s_axis_tuser,   // line_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // out_char[6:0], byte_sum[38:7], zero[39]
  output logic        m_axis_tlast    // end_of_line
);

  logic              bnd_valid, bnd_ready;
  bundle_t           bnd;
  logic [CHAR_W-1:0] out_char;
  logic [SUM_W-1:0]  byte_sum;
  emit_stat_t        stat;

  uule_encode #(
    .MAX_LINE_BYTES(MAX_LINE_BYTES)
  ) u_encode (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .data_byte  (s_axis_tdata[7:0]),
    .line_start (s_axis_tuser),
    .line_length(s_axis_tdata[13:8]),
    .bnd_valid  (bnd_valid),
    .bnd_ready  (bnd_ready),
    .bnd        (bnd)
  );

  uule_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .bnd_valid  (bnd_valid),
    .bnd_ready  (bnd_ready),
    .bnd        (bnd),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_char   (out_char),
    .end_of_line(m_axis_tlast),
    .byte_sum   (byte_sum),
    .stat       (stat)
  );

  assign m_axis_tdata = {1'b0, byte_sum, out_char};

  // Emitter index stays within the held characters
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    stat.busy |-> (stat.idx <= stat.last_idx))
    else $error("emitter index past last character");

  // All characters of one item report the same byte sum
  a_sum_stable: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tready && (stat.idx != stat.last_idx))
      |=> $stable(m_axis_tdata[38:7]))
    else $error("byte sum changed inside an item's characters");

  // An idle output side never stalls the input side
  a_idle_ready: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled while output is empty");

endmodule

[verif/tb_uu_line_encoder_top.sv]
`timescale 1ns / 100ps

module tb_uu_line_encoder_top;
  import uule_pkg::*;

  localparam int RANDOM_ITEMS = 145;
  localparam int LONG_HOLD    = 250;

  // One input item: data byte, line start flag and line length
  typedef struct {
    logic [BYTE_W-1:0] data;
    logic              start;
    logic [LEN_W-1:0]  len;
  } line_item_t;

  // One encoded character as it should leave the block
  typedef struct {
    logic [CHAR_W-1:0] ch;
    logic              eol;
    logic [SUM_W-1:0]  sum;
  } enc_char_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;   // data_byte[7:0], line_length[13:8], zero[15:14]
  logic        s_axis_tuser = 1'b0; // line_start
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;        // out_char[6:0], byte_sum[38:7], zero[39]
  logic        m_axis_tlast;        // end_of_line

  uu_line_encoder_top i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  line_item_t pending[$];
  enc_char_t  expected_chars[$];
  line_item_t cur_item;

  // Encoder state mirrored by the predictor
  logic [BYTE_W-1:0] grp_bytes[2];
  logic [1:0]        grp_fill;
  logic [LEN_W-1:0]  line_left;
  logic [SUM_W-1:0]  sum_acc;

  int    total_items;
  int    n_in;
  int    n_chars;
  int    n_lines;
  int    n_dropped;
  int    n_errors;
  int    src_gap;
  int    snk_gap;
  logic  in_fire;
  logic  hold_on;

  initial begin
    grp_bytes = '{default: '0};
    grp_fill  = '0;
    line_left = '0;
    sum_acc   = '0;
    n_in      = 0;
    n_chars   = 0;
    n_lines   = 0;
    n_dropped = 0;
    n_errors  = 0;
    src_gap   = 0;
    snk_gap   = 0;
    in_fire   = 1'b0;
    hold_on   = 1'b0;
  end

  // 6-bit value to printable character, zero maps to backquote
  function automatic logic [CHAR_W-1:0] char_of_six(input logic [5:0] v);
    return (v == 6'd0) ? CHAR_ZERO : CHAR_BASE + CHAR_W'(v);
  endfunction

  task automatic push_char(input logic [CHAR_W-1:0] ch, input logic eol);
    enc_char_t e;
    e.ch  = ch;
    e.eol = eol;
    e.sum = sum_acc;
    expected_chars.push_back(e);
  endtask

  // Predict the characters caused by one accepted item
  task automatic encode_byte(input line_item_t it);
    logic [LEN_W-1:0] len;
    logic             hdr;
    logic             is_last;
    logic [23:0]      word;
    hdr = 1'b0;
    len = it.len;
    if (it.start) begin
      if (len > LEN_W'(MAX_LINE_BYTES_DEF)) len = LEN_W'(MAX_LINE_BYTES_DEF);
      grp_bytes = '{default: '0};
      grp_fill  = '0;
      line_left = len;
      if (len == '0) begin
        push_char(CHAR_BASE, 1'b1);
        return;
      end
      hdr = 1'b1;
    end else if (line_left == '0) begin
      return; // stray byte, ignored
    end
    sum_acc   = sum_acc + SUM_W'(it.data);
    line_left = line_left - LEN_W'(1);
    is_last   = (line_left == '0);
    // header carries the sum including this byte
    if (hdr) push_char(CHAR_BASE + CHAR_W'(len), 1'b0);
    if (grp_fill < 2) begin
      grp_bytes[grp_fill[0]] = it.data;
      grp_fill = grp_fill + 2'd1;
      if (!is_last) return;
      word = {grp_bytes[0], grp_bytes[1], 8'h00};
    end else begin
      word = {grp_bytes[0], grp_bytes[1], it.data};
    end
    push_char(char_of_six(word[23:18]), 1'b0);
    push_char(char_of_six(word[17:12]), 1'b0);
    push_char(char_of_six(word[11:6]), 1'b0);
    push_char(char_of_six(word[5:0]), is_last);
    grp_bytes = '{default: '0};
    grp_fill  = '0;
  endtask

  task automatic note_mismatch(input string msg);
    n_errors++;
    if (n_errors <= 10) $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  task automatic push_item(input logic [7:0] data, input logic start, input logic [5:0] len);
    line_item_t it;
    it.data  = data;
    it.start = start;
    it.len   = len;
    pending.push_back(it);
  endtask

  // Idling windows: none in the middle stretch and none at the tail
  function automatic bit src_idle_ok();
    return (n_in < 60) || (n_in >= 95 && n_in + 40 < total_items);
  endfunction

  function automatic bit snk_idle_ok();
    return (n_in < 80) || (n_in >= 95 && n_in + 40 < total_items);
  endfunction

  // Input driver, falling edge
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_fire) begin
      if (src_gap > 0) begin
        src_gap       <= src_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (pending.size() == 0) begin
        s_axis_tvalid <= 1'b0;
      end else if (src_idle_ok() && $urandom_range(0, 5) == 0) begin
        src_gap       <= $urandom_range(0, 10);
        s_axis_tvalid <= 1'b0;
      end else begin
        cur_item       = pending.pop_front();
        s_axis_tdata  <= {2'b00, cur_item.len, cur_item.data};
        s_axis_tuser  <= cur_item.start;
        s_axis_tvalid <= 1'b1;
      end
    end
  end

  // Output ready, falling edge
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (snk_gap > 0) begin
      snk_gap       <= snk_gap - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_on) begin
      m_axis_tready <= 1'b0;
    end else if (snk_idle_ok() && $urandom_range(0, 6) == 0) begin
      snk_gap       <= $urandom_range(0, 10);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Monitor: predict on accepted input, check accepted output
  always @(posedge clk) begin
    line_item_t acc;
    enc_char_t  exp_c;
    if (rst) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= s_axis_tvalid && s_axis_tready;
      if (s_axis_tvalid && s_axis_tready) begin
        acc.data  = s_axis_tdata[7:0];
        acc.len   = s_axis_tdata[13:8];
        acc.start = s_axis_tuser;
        encode_byte(acc);
        n_in++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        n_chars++;
        if (expected_chars.size() == 0) begin
          note_mismatch($sformatf("unexpected char %02h eol %0b sum %08h",
                                  m_axis_tdata[6:0], m_axis_tlast, m_axis_tdata[38:7]));
        end else begin
          exp_c = expected_chars.pop_front();
          if (m_axis_tdata[6:0] !== exp_c.ch || m_axis_tlast !== exp_c.eol ||
              m_axis_tdata[38:7] !== exp_c.sum)
            note_mismatch($sformatf("char %02h/%02h eol %0b/%0b sum %08h/%08h (exp/got)",
                                    exp_c.ch, m_axis_tdata[6:0], exp_c.eol, m_axis_tlast,
                                    exp_c.sum, m_axis_tdata[38:7]));
        end
      end
    end
  end

  // Long receiver hold-off so the block backs up into its input
  initial begin
    wait (!rst);
    wait (n_in >= 70);
    @(negedge clk) hold_on <= 1'b1;
    repeat (LONG_HOLD) @(negedge clk);
    hold_on <= 1'b0;
  end

  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // Stimulus and end of run
  initial begin
    int n_real;
    int len;
    int eff;
    int cnt;
    int r;

    // stray byte straight after reset
    push_item(8'hFF, 1'b0, 6'd63);
    // zero-length line, byte not summed
    push_item(8'hAA, 1'b1, 6'd0);
    // one-byte line: header plus padded group
    push_item(8'hFF, 1'b1, 6'd1);
    // two zero bytes: every group character is backquote
    push_item(8'h00, 1'b1, 6'd2);
    push_item(8'h00, 1'b0, 6'd0);
    // full group
    push_item(8'hFF, 1'b1, 6'd3);
    push_item(8'h80, 1'b0, 6'd21);
    push_item(8'h01, 1'b0, 6'd42);
    // overlong length, saturated, then abandoned by a new line
    push_item(8'h12, 1'b1, 6'd63);
    push_item(8'h34, 1'b0, 6'd0);
    push_item(8'hFE, 1'b1, 6'd4);
    push_item(8'h01, 1'b0, 6'd63);
    push_item(8'h7F, 1'b0, 6'd0);
    push_item(8'h80, 1'b0, 6'd0);
    // byte after the line has closed
    push_item(8'h55, 1'b0, 6'd5);
    // five-byte line, two-byte final group
    push_item(8'h0F, 1'b1, 6'd5);
    push_item(8'hF0, 1'b0, 6'd0);
    push_item(8'h3C, 1'b0, 6'd0);
    push_item(8'hC3, 1'b0, 6'd0);
    push_item(8'h5A, 1'b0, 6'd0);
    n_lines   = 7;
    n_dropped = 1;

    // random lines, mostly short and well formed
    n_real = 0;
    while (n_real < RANDOM_ITEMS) begin
      r = $urandom_range(0, 19);
      if (r == 0) begin
        push_item(8'($urandom), 1'b0, 6'($urandom));
      end else begin
        r = $urandom_range(0, 19);
        if (r == 0)      len = 0;
        else if (r <= 2) len = $urandom_range(40, 63);
        else             len = $urandom_range(1, 9);
        eff = (len > MAX_LINE_BYTES_DEF) ? MAX_LINE_BYTES_DEF : len;
        cnt = (eff == 0) ? 1 : eff;
        if (eff > 1 && $urandom_range(0, 9) == 0) begin
          cnt = $urandom_range(1, eff - 1);
          n_dropped++;
        end
        push_item(8'($urandom), 1'b1, 6'(len));
        for (int i = 1; i < cnt; i++) push_item(8'($urandom), 1'b0, 6'($urandom));
        n_real += cnt;
        n_lines++;
      end
    end
    total_items = pending.size();

    repeat (3) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    wait (n_in == total_items);
    wait (expected_chars.size() == 0);
    repeat (20) @(posedge clk);
    if (expected_chars.size() != 0)
      note_mismatch($sformatf("%0d characters never arrived", expected_chars.size()));

    $display("Run covered %0d items in %0d lines (%0d abandoned), %0d characters seen,",
             total_items, n_lines, n_dropped, n_chars);
    $display("with random stalls on both sides and a %0d-cycle receiver hold-off.",
             LONG_HOLD);
    if (n_errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches in total", n_errors);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/uule_pkg.sv
hdl/uule_encode.sv
hdl/uule_emit.sv
hdl/uu_line_encoder_top.sv
verif/tb_uu_line_encoder_top.sv
